/* sv/mm_pkg.sv */
// Shared types and constants for the matrix multiply block.
// No dependencies; every other file of the block but mm_mem imports this package.

package mm_pkg;

	// Default largest matrix dimension.
	localparam int MM_MAX_DIM_DEF = 8;

	// Element and accumulator widths, Q16.16 elements.
	localparam int DATA_W = 32;
	localparam int ACC_W  = 64;
	localparam int FRAC_W = 16;
	localparam int POS_W  = 3;
	localparam int CFG_W  = 4;
	localparam int CIDX_W = 2;

	// Opcodes of an input transaction.
	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_MULT   = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_ROWS_A = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_COLS_A = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_ROWS_B = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_COLS_B = 2'd3;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	// Tag that travels with each memory read through the datapath.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last_k;
		logic             last_el;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} seq_tag_t;

endpackage

/* sv/mm_mem.sv */
// Simple dual-port synchronous memory: one write port, one registered read port.
// Depends on nothing; used for both matrix stores.

module mm_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/mm_seq.sv */
// Sequencer: decodes input transactions, writes loads to the stores and walks i, j, k
// for a multiply. Depends on mm_pkg.

module mm_seq #(
	parameter int MAX_DIM = mm_pkg::MM_MAX_DIM_DEF,
	parameter int DW      = 4,
	parameter int AW      = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic [mm_pkg::POS_W-1:0]   row,
	input  logic [mm_pkg::POS_W-1:0]   col,
	input  logic [mm_pkg::DATA_W-1:0]  value,
	input  logic [DW-1:0]              ra,
	input  logic [DW-1:0]              ca,
	input  logic [DW-1:0]              rb,
	input  logic [DW-1:0]              cb,
	output logic                       running,
	output logic                       a_we,
	output logic                       b_we,
	output logic [AW-1:0]              waddr,
	output logic [mm_pkg::DATA_W-1:0]  wdata,
	output logic                       rd_en,
	output logic [AW-1:0]              a_raddr,
	output logic [AW-1:0]              b_raddr,
	output mm_pkg::seq_tag_t           tag,
	output logic                       err_stb
);

	import mm_pkg::*;

	// Counter width: holds any index below MAX_DIM and at least a result position.
	localparam int CW = (DW > POS_W) ? DW : POS_W;

	seq_state_t    state_q, state_d;
	logic [CW-1:0] i_q, j_q, k_q;
	logic [CW-1:0] i_d, j_d, k_d;
	logic          accept;
	logic          row_ok_a, col_ok_a, row_ok_b, col_ok_b;
	logic          i_end, j_end, k_end;

	assign accept = start && !busy;

	// Load bounds against the effective sizes.
	assign row_ok_a = row < ra;
	assign col_ok_a = col < ca;
	assign row_ok_b = row < rb;
	assign col_ok_b = col < cb;

	// Store writes happen only while no multiply runs, so reads never overlap them.
	assign waddr = AW'(row * MAX_DIM + col);
	assign wdata = value;

	// End of each loop level.
	assign k_end = (k_q + CW'(1)) == CW'(ca);
	assign j_end = (j_q + CW'(1)) == CW'(cb);
	assign i_end = (i_q + CW'(1)) == CW'(ra);

	// Read addresses: A is walked along row i, B down column j.
	assign a_raddr = AW'(i_q * MAX_DIM + k_q);
	assign b_raddr = AW'(k_q * MAX_DIM + j_q);

	// State register and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	// Next state, counter updates and decode of accepted transactions.
	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		a_we        = 1'b0;
		b_we        = 1'b0;
		err_stb     = 1'b0;
		rd_en       = 1'b0;
		tag         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_LOAD_A: a_we = row_ok_a && col_ok_a;
						OP_LOAD_B: b_we = row_ok_b && col_ok_b;
						OP_MULT: begin
							if (ca != rb) begin
								err_stb = 1'b1;
							end else begin
								state_d = ST_RUN;
								i_d     = '0;
								j_d     = '0;
								k_d     = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RUN: begin
				// Issue one read pair per cycle and tag it.
				rd_en       = 1'b1;
				tag.valid   = 1'b1;
				tag.first   = (k_q == '0);
				tag.last_k  = k_end;
				tag.last_el = k_end && j_end && i_end;
				tag.row     = i_q[POS_W-1:0];
				tag.col     = j_q[POS_W-1:0];
				if (!k_end) begin
					k_d = k_q + CW'(1);
				end else begin
					k_d = '0;
					if (!j_end) begin
						j_d = j_q + CW'(1);
					end else begin
						j_d = '0;
						if (!i_end) begin
							i_d = i_q + CW'(1);
						end else begin
							i_d     = '0;
							state_d = ST_IDLE;
						end
					end
				end
			end
		endcase
	end

	assign running = (state_q == ST_RUN);

endmodule

/* sv/mm_mac.sv */
// Multiply-accumulate datapath: product register, Q16 floor, 64-bit accumulator,
// saturation and the result register. Depends on mm_pkg.

module mm_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mm_pkg::seq_tag_t           tag,
	input  logic                       err_stb,
	input  logic [mm_pkg::DATA_W-1:0]  a_rdata,
	input  logic [mm_pkg::DATA_W-1:0]  b_rdata,
	output logic                       pipe_busy,
	output logic                       valid,
	output logic [mm_pkg::POS_W-1:0]   out_row,
	output logic [mm_pkg::POS_W-1:0]   out_col,
	output logic [mm_pkg::DATA_W-1:0]  prod_value,
	output logic                       last,
	output logic                       error
);

	import mm_pkg::*;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	seq_tag_t                 tag_s1, tag_s2;
	logic signed [ACC_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_floor;
	logic signed [ACC_W-1:0]  acc_sum;
	logic [ACC_W-DATA_W:0]    acc_hi;
	logic [DATA_W-1:0]        sat_val;
	logic                     valid_q, last_q, error_q;
	logic [POS_W-1:0]         row_q, col_q;
	logic [DATA_W-1:0]        val_q;

	// Tags follow the memory read and the multiply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	// Full 64-bit product of two Q16.16 elements.
	always_ff @(posedge clk) begin
		prod_s2 <= ACC_W'($signed(a_rdata)) * ACC_W'($signed(b_rdata));
	end

	// Floor to Q.16 and add to the running sum, restarting at the first term.
	assign prod_floor = prod_s2 >>> FRAC_W;
	assign acc_sum    = (tag_s2.first ? '0 : acc_q) + prod_floor;

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= acc_sum;
		end
	end

	// Saturate to 32 bits: in range when the top bits all match the sign.
	assign acc_hi  = acc_sum[ACC_W-1:DATA_W-1];
	always_comb begin
		if ((&acc_hi) || !(|acc_hi)) begin
			sat_val = acc_sum[DATA_W-1:0];
		end else if (acc_sum[ACC_W-1]) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = SAT_MAX;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= err_stb || (tag_s2.valid && tag_s2.last_k);
		end
	end

	// Result payload: an error result carries zero fields.
	always_ff @(posedge clk) begin
		if (err_stb) begin
			row_q   <= '0;
			col_q   <= '0;
			val_q   <= '0;
			last_q  <= 1'b1;
			error_q <= 1'b1;
		end else begin
			row_q   <= tag_s2.row;
			col_q   <= tag_s2.col;
			val_q   <= sat_val;
			last_q  <= tag_s2.last_el;
			error_q <= 1'b0;
		end
	end

	assign pipe_busy  = tag_s1.valid || tag_s2.valid;
	assign valid      = valid_q;
	assign out_row    = row_q;
	assign out_col    = col_q;
	assign prod_value = val_q;
	assign last       = last_q;
	assign error      = error_q;

endmodule

/* sv/matrix_multiply.sv */
// Top level of the matrix multiply block: configuration registers, stores and datapath.
// Depends on mm_pkg, mm_mem, mm_seq and mm_mac.
//
// Usage:
//   Input transactions are taken on a rising edge with start high and busy low.
//   opcode 0 and 1 store value into A or B at (row, col); a position outside the
//   configured size is dropped. Loads are taken back to back and give no result.
//   opcode 2 multiplies. It reads one A and one B element per cycle from the two
//   stores, rows_a*cols_b*cols_a read pairs for a run of rows_a x cols_b results;
//   busy stays high until the last product has been summed. Results appear
//   row-major, the final one with last set. With cols_a differing from rows_b a
//   single error result appears in the cycle after the start and busy stays low.
//   Each result is shown for exactly one cycle with valid high; the receiver
//   cannot stall it.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
//   ready; the user must write it only while the block is idle, which the block
//   does not enforce. Reset sets every size register to 1 and idles the
//   sequencer; store contents are undefined until written.

module matrix_multiply #(
	parameter int MAX_DIM = mm_pkg::MM_MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic [mm_pkg::POS_W-1:0]   row,
	input  logic [mm_pkg::POS_W-1:0]   col,
	input  logic [mm_pkg::DATA_W-1:0]  value,
	output logic                       valid,
	output logic [mm_pkg::POS_W-1:0]   out_row,
	output logic [mm_pkg::POS_W-1:0]   out_col,
	output logic [mm_pkg::DATA_W-1:0]  prod_value,
	output logic                       last,
	output logic                       error,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mm_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]   cfg_data
);

	import mm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_DIM + 1);

	logic [CFG_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [DW-1:0]     ra, ca, rb, cb;
	logic              running, pipe_busy;
	logic              a_we, b_we, rd_en, err_stb;
	logic [AW-1:0]     waddr, a_raddr, b_raddr;
	logic [DATA_W-1:0] wdata, a_rdata, b_rdata;
	seq_tag_t          tag;

	// Register value clamped into 1 .. MAX_DIM.
	function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] r);
		logic [DW-1:0] d;
		if (r == '0) begin
			d = DW'(1);
		end else if (r > MAX_DIM) begin
			d = DW'(MAX_DIM);
		end else begin
			d = DW'(r);
		end
		return d;
	endfunction

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CFG_W'(1);
			cols_a_q <= CFG_W'(1);
			rows_b_q <= CFG_W'(1);
			cols_b_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROWS_A: rows_a_q <= cfg_data;
				CFG_COLS_A: cols_a_q <= cfg_data;
				CFG_ROWS_B: rows_b_q <= cfg_data;
				CFG_COLS_B: cols_b_q <= cfg_data;
			endcase
		end
	end

	assign ra = eff_dim(rows_a_q);
	assign ca = eff_dim(cols_a_q);
	assign rb = eff_dim(rows_b_q);
	assign cb = eff_dim(cols_b_q);

	// Busy while reads are issued and until the last product has been summed.
	assign busy = running || pipe_busy;

	mm_seq #(
		.MAX_DIM (MAX_DIM),
		.DW      (DW),
		.AW      (AW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.opcode  (opcode),
		.row     (row),
		.col     (col),
		.value   (value),
		.ra      (ra),
		.ca      (ca),
		.rb      (rb),
		.cb      (cb),
		.running (running),
		.a_we    (a_we),
		.b_we    (b_we),
		.waddr   (waddr),
		.wdata   (wdata),
		.rd_en   (rd_en),
		.a_raddr (a_raddr),
		.b_raddr (b_raddr),
		.tag     (tag),
		.err_stb (err_stb)
	);

	mm_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DATA_W)
	) u_mem_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mm_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DATA_W)
	) u_mem_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	mm_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag        (tag),
		.err_stb    (err_stb),
		.a_rdata    (a_rdata),
		.b_rdata    (b_rdata),
		.pipe_busy  (pipe_busy),
		.valid      (valid),
		.out_row    (out_row),
		.out_col    (out_col),
		.prod_value (prod_value),
		.last       (last),
		.error      (error)
	);

endmodule

/* sv/mm_checker.sv */
// Port-level checks on the matrix multiply block, bound to the top level.
// Depends on mm_pkg and matrix_multiply.

module mm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [1:0]                 opcode,
	input logic                       valid,
	input logic [mm_pkg::POS_W-1:0]   out_row,
	input logic [mm_pkg::POS_W-1:0]   out_col,
	input logic [mm_pkg::DATA_W-1:0]  prod_value,
	input logic                       last,
	input logic                       error
);

	import mm_pkg::*;

	// An error result is the only result of its run and carries zero fields.
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error |-> last && out_row == '0 && out_col == '0 && prod_value == '0)
		else $error("error result with nonzero fields or without last");

	// The final result of a normal run comes out after the pipeline has drained.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last && !error |-> !busy)
		else $error("final result while still busy");

	// An accepted multiply either runs or reports an error at once.
	a_mult_go: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_MULT |=> busy || (valid && error))
		else $error("multiply transaction neither started nor rejected");

	// Without a running multiply or a new one, no result appears.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !(start && opcode == OP_MULT) |=> !valid)
		else $error("result without a multiply transaction");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply: element loads, products and size registers.
// Depends on mm_pkg and the matrix_multiply RTL; nothing else is read or needed.

module testbench;
	import mm_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int MAX_DIM     = MM_MAX_DIM_DEF;
	localparam int RAND_ITEMS  = 390;
	localparam int SETTLE_CYC  = 8;
	localparam int DRAIN_CYC   = 40;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int SEQ_PER_SET = 4;
	localparam int PLAN_N      = 9;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint     Q_MAX     = 64'sd2147483647;
	localparam longint     Q_MIN     = -64'sd2147483648;

	// One element of C as it leaves the block.
	typedef struct packed {
		logic [POS_W-1:0]  r;
		logic [POS_W-1:0]  c;
		logic [DATA_W-1:0] v;
		logic              last;
		logic              err;
	} prod_t;

	localparam prod_t NO_RES = '0;

	// How a directed row is handled.
	typedef enum logic [1:0] {
		ROW_SIZE,
		ROW_MODEL,
		ROW_FIXED
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        op;
		logic [POS_W-1:0]  r;
		logic [POS_W-1:0]  c;
		logic [DATA_W-1:0] v;
		logic [CIDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]  reg_val;
		prod_t             want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          opcode;
	logic [POS_W-1:0]    row;
	logic [POS_W-1:0]    col;
	logic [DATA_W-1:0]   value;
	logic                valid;
	logic [POS_W-1:0]    out_row;
	logic [POS_W-1:0]    out_col;
	logic [DATA_W-1:0]   prod_value;
	logic                last;
	logic                error;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	// Predictor state: size registers, both stores and which elements hold data.
	logic [CFG_W-1:0]         size_reg [4];
	logic signed [DATA_W-1:0] a_mem [MAX_DIM*MAX_DIM];
	logic signed [DATA_W-1:0] b_mem [MAX_DIM*MAX_DIM];
	bit                       a_set [MAX_DIM*MAX_DIM];
	bit                       b_set [MAX_DIM*MAX_DIM];
	prod_t                    c_pending [$];

	int item_cnt;
	int idle_pct;
	int bad_cnt;
	int quiet;

	// Directed rows, run right after reset with every size register at 1.
	stim_row_t directed_vec [25] = '{
		'{ROW_MODEL, OP_LOAD_A, 0, 0, 32'h0001_0000, 0, 0, NO_RES},
		'{ROW_MODEL, OP_LOAD_B, 0, 0, 32'h0002_0000, 0, 0, NO_RES},
		'{ROW_FIXED, OP_MULT,   0, 0, 32'h0, 0, 0, '{0, 0, 32'h0002_0000, 1, 0}},
		'{ROW_MODEL, OP_LOAD_A, 0, 0, 32'h7FFF_FFFF, 0, 0, NO_RES},
		'{ROW_MODEL, OP_LOAD_B, 0, 0, 32'h7FFF_FFFF, 0, 0, NO_RES},
		'{ROW_FIXED, OP_MULT,   0, 0, 32'h0, 0, 0, '{0, 0, 32'h7FFF_FFFF, 1, 0}},
		'{ROW_MODEL, OP_LOAD_B, 0, 0, 32'h8000_0000, 0, 0, NO_RES},
		'{ROW_FIXED, OP_MULT,   0, 0, 32'h0, 0, 0, '{0, 0, 32'h8000_0000, 1, 0}},
		'{ROW_MODEL, OP_LOAD_A, 0, 0, 32'h8000_0000, 0, 0, NO_RES},
		'{ROW_FIXED, OP_MULT,   0, 0, 32'h0, 0, 0, '{0, 0, 32'h7FFF_FFFF, 1, 0}},
		'{ROW_MODEL, OP_LOAD_A, 1, 0, 32'h1234_5678, 0, 0, NO_RES},
		'{ROW_MODEL, OP_LOAD_B, 7, 7, 32'hFFFF_FFFF, 0, 0, NO_RES},
		'{ROW_MODEL, OP_UNUSED, 7, 7, 32'hFFFF_FFFF, 0, 0, NO_RES},
		'{ROW_FIXED, OP_MULT,   7, 7, 32'hFFFF_FFFF, 0, 0, '{0, 0, 32'h7FFF_FFFF, 1, 0}},
		'{ROW_MODEL, OP_LOAD_A, 0, 0, 32'hFFFF_FFFF, 0, 0, NO_RES},
		'{ROW_MODEL, OP_LOAD_B, 0, 0, 32'h0000_0001, 0, 0, NO_RES},
		'{ROW_FIXED, OP_MULT,   0, 0, 32'h0, 0, 0, '{0, 0, 32'hFFFF_FFFF, 1, 0}},
		'{ROW_SIZE,  OP_LOAD_A, 0, 0, 32'h0, CFG_COLS_A, 2, NO_RES},
		'{ROW_FIXED, OP_MULT,   0, 0, 32'h0, 0, 0, '{0, 0, 32'h0, 1, 1}},
		'{ROW_SIZE,  OP_LOAD_A, 0, 0, 32'h0, CFG_ROWS_B, 2, NO_RES},
		'{ROW_MODEL, OP_LOAD_A, 0, 1, 32'h0003_0000, 0, 0, NO_RES},
		'{ROW_MODEL, OP_LOAD_B, 1, 0, 32'hFFFE_8000, 0, 0, NO_RES},
		'{ROW_MODEL, OP_MULT,   0, 0, 32'h0, 0, 0, NO_RES},
		'{ROW_SIZE,  OP_LOAD_A, 0, 0, 32'h0, CFG_ROWS_A, 0, NO_RES},
		'{ROW_MODEL, OP_MULT,   3, 5, 32'hA5A5_5A5A, 0, 0, NO_RES}
	};

	// Size settings per phase, in register order; the extremes 0 and 15 are included.
	logic [CFG_W-1:0] size_plan [PLAN_N][4] = '{
		'{2, 2, 2, 2},
		'{0, 0, 0, 0},
		'{3, 4, 4, 2},
		'{15, 15, 15, 15},
		'{1, 8, 8, 1},
		'{8, 1, 1, 8},
		'{4, 3, 5, 2},
		'{2, 5, 5, 3},
		'{9, 0, 1, 12}
	};

	matrix_multiply #(.MAX_DIM(MAX_DIM)) DUT (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Effective size: zero acts as one, anything above the store acts as the store size.
	function automatic int dim_of(logic [CIDX_W-1:0] idx);
		if (size_reg[idx] == 0)
			return 1;
		if (size_reg[idx] > MAX_DIM)
			return MAX_DIM;
		return int'(size_reg[idx]);
	endfunction

	// Applies one accepted transaction; a product run queues its elements of C when record is set.
	// Returns whether the transaction did anything.
	function automatic bit step_matmul(logic [1:0] op, logic [POS_W-1:0] r,
			logic [POS_W-1:0] c, logic [DATA_W-1:0] v, bit record);
		int     ra, ca, rb, cb, i, j, k;
		longint acc;
		prod_t  e;
		ra = dim_of(CFG_ROWS_A);
		ca = dim_of(CFG_COLS_A);
		rb = dim_of(CFG_ROWS_B);
		cb = dim_of(CFG_COLS_B);
		case (op)
			OP_LOAD_A: begin
				if (r >= ra || c >= ca)
					return 0;
				a_mem[r*MAX_DIM + c] = v;
				a_set[r*MAX_DIM + c] = 1'b1;
				return 1;
			end
			OP_LOAD_B: begin
				if (r >= rb || c >= cb)
					return 0;
				b_mem[r*MAX_DIM + c] = v;
				b_set[r*MAX_DIM + c] = 1'b1;
				return 1;
			end
			OP_MULT: begin
				if (!record)
					return 1;
				if (ca != rb) begin
					e = NO_RES;
					e.last = 1'b1;
					e.err = 1'b1;
					c_pending.push_back(e);
					return 1;
				end
				for (i = 0; i < ra; i++) begin
					for (j = 0; j < cb; j++) begin
						// Each product is floored to Q16.16 before it is summed.
						acc = 0;
						for (k = 0; k < ca; k++)
							acc += (longint'(a_mem[i*MAX_DIM + k]) *
								longint'(b_mem[k*MAX_DIM + j])) >>> FRAC_W;
						e.r = POS_W'(i);
						e.c = POS_W'(j);
						if (acc > Q_MAX)
							e.v = 32'h7FFF_FFFF;
						else if (acc < Q_MIN)
							e.v = 32'h8000_0000;
						else
							e.v = acc[DATA_W-1:0];
						e.last = (i == ra - 1) && (j == cb - 1);
						e.err = 1'b0;
						c_pending.push_back(e);
					end
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// Finds an element that a product run would read but that was never written.
	function automatic bit find_hole(output bit in_b, output logic [POS_W-1:0] r,
			output logic [POS_W-1:0] c);
		int i, j;
		in_b = 1'b0;
		r = '0;
		c = '0;
		if (dim_of(CFG_COLS_A) != dim_of(CFG_ROWS_B))
			return 0;
		for (i = 0; i < dim_of(CFG_ROWS_A); i++)
			for (j = 0; j < dim_of(CFG_COLS_A); j++)
				if (!a_set[i*MAX_DIM + j]) begin
					r = POS_W'(i);
					c = POS_W'(j);
					return 1;
				end
		in_b = 1'b1;
		for (i = 0; i < dim_of(CFG_ROWS_B); i++)
			for (j = 0; j < dim_of(CFG_COLS_B); j++)
				if (!b_set[i*MAX_DIM + j]) begin
					r = POS_W'(i);
					c = POS_W'(j);
					return 1;
				end
		return 0;
	endfunction

	// Element values: the extremes, zero, small values that do not saturate, and noise.
	function automatic logic [DATA_W-1:0] rand_elem();
		logic [DATA_W-1:0] m;
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4: begin
				m = $urandom_range(0, 32'h0004_0000);
				return $urandom_range(0, 1) ? -m : m;
			end
			default: return $urandom();
		endcase
	endfunction

	// Presents one transaction, with a random gap in front, and waits until it is taken.
	task automatic send_item(logic [1:0] op, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
			logic [DATA_W-1:0] v, bit record);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
		start <= 1'b1;
		opcode <= op;
		row <= r;
		col <= c;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		void'(step_matmul(op, r, c, v, record));
		item_cnt++;
	endtask

	// Holds off until every queued element of C has come and the block is quiet.
	task automatic settle();
		start <= 1'b0;
		while (busy || c_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC)
			@(posedge clk);
	endtask

	// Writes one size register; the caller lowers cfg_valid after its last write.
	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		size_reg[idx] = d;
	endtask

	// Programs the sizes of one phase, from the plan first and at random after it.
	task automatic start_phase(int n);
		logic [CFG_W-1:0] sz [4];
		int q;
		if (n < PLAN_N) begin
			sz = size_plan[n];
		end else begin
			for (q = 0; q < 4; q++)
				sz[q] = CFG_W'($urandom_range(0, 15));
			if ($urandom_range(0, 3) != 0)
				sz[CFG_ROWS_B] = sz[CFG_COLS_A];
		end
		settle();
		for (q = 0; q < 4; q++)
			write_reg(CIDX_W'(q), sz[q]);
		cfg_valid <= 1'b0;
	endtask

	// A burst of loads with some noise, then usually a product over filled stores.
	task automatic run_sequence();
		int               n;
		bit               in_b;
		logic [POS_W-1:0] r, c;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(0, 9) < 2) begin
				if ($urandom_range(0, 1))
					send_item(OP_UNUSED, POS_W'($urandom_range(0, 7)),
						POS_W'($urandom_range(0, 7)), $urandom(), 1'b1);
				else
					send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
						POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
						rand_elem(), 1'b1);
			end else begin
				in_b = 1'($urandom_range(0, 1));
				r = POS_W'($urandom_range(0, dim_of(in_b ? CFG_ROWS_B : CFG_ROWS_A) - 1));
				c = POS_W'($urandom_range(0, dim_of(in_b ? CFG_COLS_B : CFG_COLS_A) - 1));
				send_item(in_b ? OP_LOAD_B : OP_LOAD_A, r, c, rand_elem(), 1'b1);
			end
		end
		if ($urandom_range(0, 5) != 0) begin
			while (find_hole(in_b, r, c))
				send_item(in_b ? OP_LOAD_B : OP_LOAD_A, r, c, rand_elem(), 1'b1);
			send_item(OP_MULT, POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
				$urandom(), 1'b1);
		end
	endtask

	// Notes one failure; only the first few are printed.
	task automatic flag_mismatch(string what, prod_t want, prod_t got);
		bad_cnt++;
		if (bad_cnt <= MAX_REPORTS)
			$display("%s: expected row %0d col %0d value %h last %b error %b",
				what, want.r, want.c, want.v, want.last, want.err,
				", got row %0d col %0d value %h last %b error %b",
				got.r, got.c, got.v, got.last, got.err);
	endtask

	// Result checker: each strobed result is compared with the oldest queued element of C.
	always @(posedge clk) begin
		prod_t got;
		prod_t want;
		got = '{out_row, out_col, prod_value, last, error};
		if (arst_n === 1'b1 && valid !== 1'b0) begin
			if (c_pending.size() == 0) begin
				flag_mismatch("result with nothing expected", NO_RES, got);
			end else begin
				want = c_pending.pop_front();
				if (valid !== 1'b1 || got !== want)
					flag_mismatch("wrong result", want, got);
			end
		end
	end

	// Watchdog: counts cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if ((start && !busy) || valid || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	// Stimulus: reset, the directed table, then random phases under changing sizes.
	initial begin
		int i, phase;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_LOAD_A;
		row = '0;
		col = '0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROWS_A;
		cfg_data = '0;
		quiet = 0;
		bad_cnt = 0;
		item_cnt = 0;
		idle_pct = 16;
		for (i = 0; i < 4; i++)
			size_reg[i] = 1;
		for (i = 0; i < MAX_DIM*MAX_DIM; i++) begin
			a_set[i] = 1'b0;
			b_set[i] = 1'b0;
		end
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_vec[i]) begin
			if (directed_vec[i].kind == ROW_SIZE) begin
				settle();
				write_reg(directed_vec[i].reg_idx, directed_vec[i].reg_val);
				cfg_valid <= 1'b0;
			end else begin
				send_item(directed_vec[i].op, directed_vec[i].r, directed_vec[i].c,
					directed_vec[i].v, directed_vec[i].kind == ROW_MODEL);
				if (directed_vec[i].kind == ROW_FIXED)
					c_pending.push_back(directed_vec[i].want);
			end
		end

		// Sender gaps: light for the first third, heavy for the second, none at the end.
		item_cnt = 0;
		phase = 0;
		while (item_cnt < RAND_ITEMS) begin
			start_phase(phase);
			phase++;
			repeat (SEQ_PER_SET) begin
				if (item_cnt < RAND_ITEMS / 3)
					idle_pct = 16;
				else if (item_cnt < 2 * RAND_ITEMS / 3)
					idle_pct = 61;
				else
					idle_pct = 0;
				run_sequence();
			end
		end

		start <= 1'b0;
		while (busy || c_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC)
			@(posedge clk);
		if (bad_cnt == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
